// ----- hdl/mlfq_pkg.sv -----
// mlfq_pkg: shared constants, action and status codes for the feedback-queue scheduler
// no dependencies; imported by mlfq_div100, mlfq_process_scheduler, mlfq_checker and tb
`timescale 1ns / 1ps
`default_nettype none

package mlfq_pkg;

  localparam int ACT_W      = 3;
  localparam int STATUS_W   = 2;
  localparam int PCT_W      = 7;
  localparam int TSLOT_W    = 4;
  localparam int OSLOT_W    = 4;
  localparam int OLVL_W     = 2;
  localparam int CHARGE_W   = 30;
  localparam int SLOTS_CFG_W = 5;
  localparam int BASE_W     = 27;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam int PCT_FULL   = 100;

  localparam logic [CHARGE_W-1:0]    CHARGE_MAX = '1;
  localparam logic [SLOTS_CFG_W-1:0] SLOTS_RST  = 5'd16;
  localparam logic [BASE_W-1:0]      BASE_RST   = 27'd10000000;

  localparam logic REG_SLOTS = 1'b0;
  localparam logic REG_BASE  = 1'b1;

  typedef enum logic [ACT_W-1:0] {
    ACT_CREATE    = 3'd0,
    ACT_DISPATCH  = 3'd1,
    ACT_EXPIRED   = 3'd2,
    ACT_EXHAUSTED = 3'd3,
    ACT_SLICED    = 3'd4,
    ACT_UNBLOCK   = 3'd5
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_NA    = 2'd2
  } status_t;

endpackage

`default_nettype wire

// ----- hdl/mlfq_div100.sv -----
// mlfq_div100: unsigned divide by 100 through multiplication by the reciprocal,
// one 16-bit slice of the reciprocal per cycle; depends on mlfq_pkg for the divisor
`timescale 1ns / 1ps
`default_nettype none

module mlfq_div100 #(
  parameter int DW = 37
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  output logic          done,
  output logic [DW-1:0] quotient
);
  import mlfq_pkg::*;

  localparam int KW   = DW + $clog2(PCT_FULL);
  localparam int MW   = KW - $clog2(PCT_FULL) + 1;
  localparam int CW   = 16;
  localparam int NCH  = (MW + CW - 1) / CW;
  localparam int MPW  = NCH * CW;
  localparam int AW   = DW + MPW;
  localparam int CNTW = $clog2(NCH + 1);

  // ceil(2^KW / 100), exact for every dividend below 2^DW
  localparam logic [63:0] RECIP = ((64'd1 << KW) + 64'(PCT_FULL - 1)) / 64'(PCT_FULL);

  logic              busy_r;
  logic              done_r;
  logic [CNTW-1:0]   cnt_r;
  logic [DW-1:0]     x_r;
  logic [MPW-1:0]    m_r;
  logic [AW-1:0]     acc_r;
  logic [DW+CW-1:0]  part;
  logic [AW-1:0]     acc_nxt;

  // top slice of the reciprocal first, shift and accumulate
  assign part    = (DW + CW)'(x_r) * (DW + CW)'(m_r[MPW-1 -: CW]);
  assign acc_nxt = {acc_r[AW-CW-1:0], {CW{1'b0}}} + AW'(part);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(NCH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= dividend;
      m_r   <= MPW'(RECIP);
      acc_r <= '0;
    end else if (busy_r) begin
      m_r   <= {m_r[MPW-CW-1:0], {CW{1'b0}}};
      acc_r <= acc_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = DW'(acc_r >> KW);

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a running division");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0)
    else $error("divider busy with zero step count");

endmodule

`default_nettype wire

// ----- hdl/mlfq_process_scheduler.sv -----
// mlfq_process_scheduler: four-level feedback-queue scheduler over a table of process slots
// depends on mlfq_pkg and mlfq_div100
//
// usage
// - input channel (in_*): one action word per handshake: create, dispatch, expired,
//   exhausted, sliced or unblock; exactly one result word per action on out_*
// - config port (apb): slots_in_use at 0x0, base_quantum_ns at 0x4; write only while idle
// - state: per-level ready queues in one synchronous ram, slot class/level/blocked in a
//   second ram; busy flags, queue pointers and the running slot in flops
// - execute: the result is computed in the execute state after acceptance and loaded into
//   the output register for every action but expired or sliced of a running slot; in_ready
//   is high only while idle, so a word is taken once the last is in the output register
// - expired and sliced of a running slot divide the charge by 100 through a reciprocal
//   multiply, one 16-bit slice a cycle, over a reciprocal of qw + 8 bits,
//   qw = max(30, 26 + LEVELS)
// - reset: all slots free, all queues empty, nothing running, config at 16 and 10 ms;
//   the queue ram needs no clearing pass, so in_ready rises right after reset
// - stall: a finished word waits in the output register; the next action is still
//   accepted and executed, then held until the output register frees up
`timescale 1ns / 1ps
`default_nettype none

module mlfq_process_scheduler #(
  parameter int SLOTS  = 16,
  parameter int LEVELS = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mlfq_pkg::PADDR_W-1:0]        paddr,
  input  logic [mlfq_pkg::PDATA_W-1:0]        pwdata,
  output logic [mlfq_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [mlfq_pkg::ACT_W-1:0]          in_action,
  input  logic                                in_real_time_class,
  input  logic [mlfq_pkg::PCT_W-1:0]          in_used_percent,
  input  logic [mlfq_pkg::TSLOT_W-1:0]        in_target_slot,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mlfq_pkg::STATUS_W-1:0]       out_status,
  output logic [mlfq_pkg::OSLOT_W-1:0]        out_slot_index,
  output logic [mlfq_pkg::OLVL_W-1:0]         out_queue_level,
  output logic [mlfq_pkg::CHARGE_W-1:0]       out_charged_ns
);
  import mlfq_pkg::*;

  localparam int SW     = $clog2(SLOTS);
  localparam int LW     = $clog2(LEVELS);
  localparam int CNTW   = $clog2(SLOTS + 1);
  localparam int QDEPTH = LEVELS * SLOTS;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QW     = (BASE_W + LEVELS - 1 > CHARGE_W) ? BASE_W + LEVELS - 1 : CHARGE_W;
  localparam int PW     = QW + PCT_W;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DIV, S_OUT} state_t;

  typedef struct packed {
    logic          rt;
    logic [LW-1:0] lvl;
    logic          blocked;
  } slot_info_t;

  // config registers
  logic [SLOTS_CFG_W-1:0] slots_in_use_r;
  logic [BASE_W-1:0]      base_r;
  logic                   cfg_wr;

  // sequencer and result registers
  state_t               state_r;
  action_t              act_r;
  logic                 rt_r;
  logic [PCT_W-1:0]     pct_r;
  logic [TSLOT_W-1:0]   tgt_r;
  logic [LW-1:0]        disp_lvl_r;
  logic                 disp_found_r;
  status_t              res_status_r;
  logic [SW-1:0]        res_slot_r;
  logic [LW-1:0]        res_lvl_r;
  logic [CHARGE_W-1:0]  res_charge_r;
  logic                 out_valid_r;
  status_t              out_status_r;
  logic [SW-1:0]        out_slot_r;
  logic [LW-1:0]        out_lvl_r;
  logic [CHARGE_W-1:0]  out_charge_r;

  // scheduler state
  logic [SLOTS-1:0]     busy_r;
  logic [SW-1:0]        head_r  [LEVELS];
  logic [SW-1:0]        tail_r  [LEVELS];
  logic [CNTW-1:0]      count_r [LEVELS];
  logic                 running_valid_r;
  logic [SW-1:0]        running_slot_r;

  // memories
  logic [SW-1:0]        qmem [QDEPTH];
  slot_info_t           smem [SLOTS];
  logic [SW-1:0]        q_rdata_r;
  slot_info_t           s_rdata_r;

  logic                 accept;
  logic                 out_free;
  logic                 out_load;
  logic [LW-1:0]        first_lvl;
  logic                 first_found;
  logic [QAW-1:0]       q_raddr;
  logic [SW-1:0]        s_raddr;
  logic [PCT_W-1:0]     pct_sat;
  logic [SLOTS-1:0]     free_vec;
  logic [SW-1:0]        free_idx;
  logic                 free_found;
  logic [SW-1:0]        tgt_idx;
  logic                 tgt_in_range;

  // execute cycle
  status_t              ex_status;
  logic [SW-1:0]        ex_slot;
  logic [LW-1:0]        ex_lvl;
  logic [CHARGE_W-1:0]  ex_charge;
  logic                 need_div;
  logic                 s_we;
  logic [SW-1:0]        s_waddr;
  slot_info_t           s_wdata;
  logic                 push_en;
  logic [LW-1:0]        push_lvl;
  logic [SW-1:0]        push_slot;
  logic                 push_ok;
  logic                 pop_en;
  logic                 busy_set;
  logic                 busy_clr;
  logic                 run_set;
  logic                 run_clr;
  logic [LW-1:0]        cur_lvl;
  logic [LW-1:0]        demote_lvl;
  logic [QW-1:0]        quantum;
  logic [PW-1:0]        prod;

  logic                 div_start;
  logic                 div_done;
  logic [PW-1:0]        div_quo;
  logic [CHARGE_W-1:0]  div_charge;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[2])
      REG_SLOTS: prdata = PDATA_W'(slots_in_use_r);
      REG_BASE:  prdata = PDATA_W'(base_r);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_in_use_r <= SLOTS_RST;
      base_r         <= BASE_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_SLOTS: slots_in_use_r <= pwdata[SLOTS_CFG_W-1:0];
        REG_BASE:  base_r         <= pwdata[BASE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // accept cycle: pick read addresses
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign pct_sat  = (in_used_percent > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : in_used_percent;

  always_comb begin
    first_lvl   = '0;
    first_found = 1'b0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (count_r[l] != '0) begin
        first_lvl   = LW'(l);
        first_found = 1'b1;
      end
    end
  end

  assign q_raddr = QAW'(first_lvl) * QAW'(SLOTS) + QAW'(head_r[first_lvl]);
  assign s_raddr = (in_action == ACT_UNBLOCK) ? SW'(in_target_slot) : running_slot_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      q_rdata_r <= qmem[q_raddr];
      s_rdata_r <= smem[s_raddr];
    end
  end

  // free slot search below the allocation limit
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      free_vec[i] = !busy_r[i] && (i < int'(slots_in_use_r));
      if (free_vec[i]) begin
        free_idx   = SW'(i);
        free_found = 1'b1;
      end
    end
  end

  assign tgt_idx      = SW'(tgt_r);
  assign tgt_in_range = int'(tgt_r) < SLOTS;

  // execute cycle: read-modify-write of the slot and queue rams
  assign cur_lvl    = s_rdata_r.lvl;
  assign demote_lvl = (cur_lvl != '0 && (int'(cur_lvl) + 1 < LEVELS)) ?
                      cur_lvl + LW'(1) : cur_lvl;
  assign quantum    = QW'(base_r) << cur_lvl;
  assign prod       = PW'(quantum) * PW'(pct_r);

  always_comb begin
    ex_status = ST_NA;
    ex_slot   = '0;
    ex_lvl    = '0;
    ex_charge = '0;
    need_div  = 1'b0;
    s_we      = 1'b0;
    s_waddr   = running_slot_r;
    s_wdata   = s_rdata_r;
    push_en   = 1'b0;
    push_lvl  = '0;
    push_slot = '0;
    pop_en    = 1'b0;
    busy_set  = 1'b0;
    busy_clr  = 1'b0;
    run_set   = 1'b0;
    run_clr   = 1'b0;
    if (state_r == S_EXEC) begin
      case (act_r)
        ACT_CREATE: begin
          ex_status = ST_EMPTY;
          if (free_found) begin
            ex_status = ST_DONE;
            ex_slot   = free_idx;
            ex_lvl    = rt_r ? '0 : LW'(1);
            busy_set  = 1'b1;
            s_we      = 1'b1;
            s_waddr   = free_idx;
            s_wdata   = '{rt: rt_r, lvl: ex_lvl, blocked: 1'b0};
            push_en   = 1'b1;
            push_lvl  = ex_lvl;
            push_slot = free_idx;
          end
        end
        ACT_DISPATCH: begin
          if (!running_valid_r) begin
            ex_status = ST_EMPTY;
            if (disp_found_r) begin
              ex_status = ST_DONE;
              ex_slot   = q_rdata_r;
              ex_lvl    = disp_lvl_r;
              pop_en    = 1'b1;
              run_set   = 1'b1;
            end
          end
        end
        ACT_EXPIRED, ACT_EXHAUSTED, ACT_SLICED: begin
          if (running_valid_r) begin
            ex_status = ST_DONE;
            ex_slot   = running_slot_r;
            ex_lvl    = cur_lvl;
            run_clr   = 1'b1;
            s_we      = 1'b1;
            if (act_r == ACT_EXHAUSTED) begin
              ex_lvl    = demote_lvl;
              ex_charge = ((quantum >> CHARGE_W) != '0) ? CHARGE_MAX : quantum[CHARGE_W-1:0];
              s_wdata   = '{rt: s_rdata_r.rt, lvl: demote_lvl, blocked: s_rdata_r.blocked};
              push_en   = 1'b1;
              push_lvl  = demote_lvl;
              push_slot = running_slot_r;
            end else begin
              need_div = 1'b1;
              busy_clr = (act_r == ACT_EXPIRED);
              s_wdata  = '{rt: s_rdata_r.rt, lvl: cur_lvl, blocked: (act_r == ACT_SLICED)};
            end
          end
        end
        ACT_UNBLOCK: begin
          if (tgt_in_range && busy_r[tgt_idx] && s_rdata_r.blocked) begin
            ex_status = ST_DONE;
            ex_slot   = tgt_idx;
            ex_lvl    = s_rdata_r.rt ? '0 : LW'(1);
            s_we      = 1'b1;
            s_waddr   = tgt_idx;
            s_wdata   = '{rt: s_rdata_r.rt, lvl: ex_lvl, blocked: 1'b0};
            push_en   = 1'b1;
            push_lvl  = ex_lvl;
            push_slot = tgt_idx;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign push_ok = push_en && (count_r[push_lvl] != CNTW'(SLOTS));

  always_ff @(posedge clk) begin
    if (push_ok) begin
      qmem[QAW'(push_lvl) * QAW'(SLOTS) + QAW'(tail_r[push_lvl])] <= push_slot;
    end
    if (s_we) begin
      smem[s_waddr] <= s_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r          <= '0;
      running_valid_r <= 1'b0;
      running_slot_r  <= '0;
      for (int l = 0; l < LEVELS; l++) begin
        head_r[l]  <= '0;
        tail_r[l]  <= '0;
        count_r[l] <= '0;
      end
    end else begin
      if (busy_set) begin
        busy_r[free_idx] <= 1'b1;
      end
      if (busy_clr) begin
        busy_r[running_slot_r] <= 1'b0;
      end
      if (run_set) begin
        running_valid_r <= 1'b1;
        running_slot_r  <= q_rdata_r;
      end
      if (run_clr) begin
        running_valid_r <= 1'b0;
      end
      if (push_ok) begin
        tail_r[push_lvl]  <= (tail_r[push_lvl] == SW'(SLOTS - 1)) ?
                             '0 : tail_r[push_lvl] + SW'(1);
        count_r[push_lvl] <= count_r[push_lvl] + CNTW'(1);
      end
      if (pop_en) begin
        head_r[disp_lvl_r]  <= (head_r[disp_lvl_r] == SW'(SLOTS - 1)) ?
                               '0 : head_r[disp_lvl_r] + SW'(1);
        count_r[disp_lvl_r] <= count_r[disp_lvl_r] - CNTW'(1);
      end
    end
  end

  // partial charge: quantum * percent / 100
  assign div_start  = (state_r == S_EXEC) && need_div;
  assign div_charge = ((div_quo >> CHARGE_W) != '0) ? CHARGE_MAX : div_quo[CHARGE_W-1:0];

  mlfq_div100 #(
    .DW(PW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod),
    .done     (div_done),
    .quotient (div_quo)
  );

  // sequencer and output register
  assign out_load = out_free && ((state_r == S_EXEC && !need_div) || state_r == S_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            act_r        <= action_t'(in_action);
            rt_r         <= in_real_time_class;
            pct_r        <= pct_sat;
            tgt_r        <= in_target_slot;
            disp_lvl_r   <= first_lvl;
            disp_found_r <= first_found;
            state_r      <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_status_r <= ex_status;
          res_slot_r   <= ex_slot;
          res_lvl_r    <= ex_lvl;
          res_charge_r <= ex_charge;
          if (need_div) begin
            state_r <= S_DIV;
          end else if (out_free) begin
            out_status_r <= ex_status;
            out_slot_r   <= ex_slot;
            out_lvl_r    <= ex_lvl;
            out_charge_r <= ex_charge;
            state_r      <= S_IDLE;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_DIV: begin
          if (div_done) begin
            res_charge_r <= div_charge;
            state_r      <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_status_r <= res_status_r;
            out_slot_r   <= res_slot_r;
            out_lvl_r    <= res_lvl_r;
            out_charge_r <= res_charge_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot_index  = OSLOT_W'(out_slot_r);
  assign out_queue_level = OLVL_W'(out_lvl_r);
  assign out_charged_ns  = out_charge_r;

  a_run_from_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(running_valid_r) |-> $past(state_r == S_EXEC && act_r == ACT_DISPATCH))
    else $error("running slot set by an action other than dispatch");

  a_div_actions: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> act_r == ACT_EXPIRED || act_r == ACT_SLICED)
    else $error("division entered for an action without a partial charge");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("division finished outside the wait state");

  a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r != S_IDLE))
    else $error("result word produced without an accepted action");

endmodule

`default_nettype wire

// ----- tb/mlfq_checker.sv -----
// mlfq_checker: watches the apb port and both word channels of the feedback-queue scheduler,
// predicts each result word from its own slot table and compares it with the word seen
// depends on mlfq_pkg
`timescale 1ns / 1ps

module mlfq_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mlfq_pkg::PADDR_W-1:0]      paddr,
  input  logic [mlfq_pkg::PDATA_W-1:0]      pwdata,
  input  logic                              pready,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [mlfq_pkg::ACT_W-1:0]        in_action,
  input  logic                              in_real_time_class,
  input  logic [mlfq_pkg::PCT_W-1:0]        in_used_percent,
  input  logic [mlfq_pkg::TSLOT_W-1:0]      in_target_slot,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [mlfq_pkg::STATUS_W-1:0]     out_status,
  input  logic [mlfq_pkg::OSLOT_W-1:0]      out_slot_index,
  input  logic [mlfq_pkg::OLVL_W-1:0]       out_queue_level,
  input  logic [mlfq_pkg::CHARGE_W-1:0]     out_charged_ns,
  output int                                fail_count,
  output int                                pending_count
);
  import mlfq_pkg::*;

  localparam int SLOT_N  = 16;
  localparam int LEVEL_N = 4;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OSLOT_W-1:0]  slot;
    logic [OLVL_W-1:0]   level;
    logic [CHARGE_W-1:0] charge;
  } sched_word_t;

  logic [SLOTS_CFG_W-1:0] slot_limit_cfg;
  logic [BASE_W-1:0]      base_quantum;
  logic [3:0]             level_fifo [LEVEL_N][$];
  bit                     busy       [SLOT_N];
  bit                     rt_class   [SLOT_N];
  bit                     blocked    [SLOT_N];
  int                     slot_lvl   [SLOT_N];
  bit                     running;
  int                     running_idx;
  sched_word_t            owed_words [$];
  int                     word_count;

  function automatic logic [CHARGE_W-1:0] clamp_charge(logic [63:0] v);
    return (v > 64'(CHARGE_MAX)) ? CHARGE_MAX : v[CHARGE_W-1:0];
  endfunction

  function void enqueue_ready(int lvl, int slot);
    if (level_fifo[lvl].size() < SLOT_N) level_fifo[lvl].push_back(4'(slot));
  endfunction

  function void clear_table();
    slot_limit_cfg = SLOTS_RST;
    base_quantum   = BASE_RST;
    for (int l = 0; l < LEVEL_N; l++) level_fifo[l].delete();
    for (int s = 0; s < SLOT_N; s++) begin
      busy[s]     = 1'b0;
      rt_class[s] = 1'b0;
      blocked[s]  = 1'b0;
      slot_lvl[s] = 0;
    end
    running     = 1'b0;
    running_idx = 0;
    owed_words.delete();
  endfunction

  function sched_word_t schedule_action(logic [ACT_W-1:0] act, logic rt,
                                        logic [PCT_W-1:0] pct_raw,
                                        logic [TSLOT_W-1:0] target);
    sched_word_t r;
    int limit;
    int cur;
    int lvl;
    int slot;
    logic [63:0] quantum;
    logic [63:0] pct;
    r = '0;
    r.status = ST_NA;
    pct = (pct_raw > PCT_W'(PCT_FULL)) ? 64'(PCT_FULL) : 64'(pct_raw);
    case (act)
      ACT_CREATE: begin
        limit = (int'(slot_limit_cfg) > SLOT_N) ? SLOT_N : int'(slot_limit_cfg);
        r.status = ST_EMPTY;
        for (int i = 0; i < limit; i++) begin
          if (!busy[i]) begin
            lvl = rt ? 0 : 1;
            busy[i]     = 1'b1;
            blocked[i]  = 1'b0;
            rt_class[i] = rt;
            slot_lvl[i] = lvl;
            enqueue_ready(lvl, i);
            r.status = ST_DONE;
            r.slot   = OSLOT_W'(i);
            r.level  = OLVL_W'(lvl);
            break;
          end
        end
      end
      ACT_DISPATCH: begin
        if (!running) begin
          r.status = ST_EMPTY;
          for (int l = 0; l < LEVEL_N; l++) begin
            if (level_fifo[l].size() != 0) begin
              slot = int'(level_fifo[l].pop_front());
              running     = 1'b1;
              running_idx = slot;
              r.status = ST_DONE;
              r.slot   = OSLOT_W'(slot);
              r.level  = OLVL_W'(l);
              break;
            end
          end
        end
      end
      ACT_EXPIRED, ACT_EXHAUSTED, ACT_SLICED: begin
        if (running) begin
          slot    = running_idx;
          cur     = slot_lvl[slot];
          running = 1'b0;
          quantum = 64'(base_quantum) << cur;
          r.status = ST_DONE;
          r.slot   = OSLOT_W'(slot);
          if (act == ACT_EXHAUSTED) begin
            // demote one level, except from the top and the bottom level
            lvl = (cur != 0 && cur + 1 < LEVEL_N) ? cur + 1 : cur;
            slot_lvl[slot] = lvl;
            enqueue_ready(lvl, slot);
            r.charge = clamp_charge(quantum);
            r.level  = OLVL_W'(lvl);
          end else begin
            r.charge = clamp_charge(quantum * pct / 64'(PCT_FULL));
            r.level  = OLVL_W'(cur);
            if (act == ACT_EXPIRED) begin
              busy[slot]    = 1'b0;
              blocked[slot] = 1'b0;
            end else begin
              blocked[slot] = 1'b1;
            end
          end
        end
      end
      ACT_UNBLOCK: begin
        if (busy[target] && blocked[target]) begin
          lvl = rt_class[target] ? 0 : 1;
          blocked[target]  = 1'b0;
          slot_lvl[target] = lvl;
          enqueue_ready(lvl, int'(target));
          r.status = ST_DONE;
          r.slot   = target;
          r.level  = OLVL_W'(lvl);
        end
      end
      default: r.status = ST_NA;
    endcase
    if (r.status != ST_DONE) begin
      r.slot   = '0;
      r.level  = '0;
      r.charge = '0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    sched_word_t want;
    sched_word_t got;
    if (!rst_n) begin
      clear_table();
      fail_count = 0;
      word_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[PADDR_W-1:2] == REG_SLOTS) slot_limit_cfg = pwdata[SLOTS_CFG_W-1:0];
        else if (paddr[PADDR_W-1:2] == REG_BASE) base_quantum = pwdata[BASE_W-1:0];
      end
      if (out_valid && out_ready) begin
        got = '{out_status, out_slot_index, out_queue_level, out_charged_ns};
        word_count++;
        if (owed_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result word %0d arrived with nothing outstanding: status %0d slot %0d",
                     word_count, got.status, got.slot);
        end else begin
          want = owed_words.pop_front();
          if (got != want) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"mismatch on result word %0d: expected status %0d slot %0d ",
                        "level %0d charge %0d, got status %0d slot %0d level %0d charge %0d"},
                       word_count, want.status, want.slot, want.level, want.charge,
                       got.status, got.slot, got.level, got.charge);
          end
        end
      end
      if (in_valid && in_ready)
        owed_words.push_back(schedule_action(in_action, in_real_time_class,
                                             in_used_percent, in_target_slot));
    end
    pending_count = owed_words.size();
  end

endmodule

// ----- tb/tb.sv -----
// tb: top of the scheduler testbench; drives directed and random action words and apb
// writes across several limit and quantum settings, then gives the verdict
// depends on mlfq_pkg, mlfq_process_scheduler and mlfq_checker
`timescale 1ns / 1ps

module tb;
  import mlfq_pkg::*;

  localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;
  localparam logic [BASE_W-1:0] BASE_FIELD_MAX = '1;
  localparam logic [BASE_W-1:0] BASE_HIGH      = 27'd100000000;

  logic                clk;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                in_valid;
  logic                in_ready;
  logic [ACT_W-1:0]    in_action;
  logic                in_real_time_class;
  logic [PCT_W-1:0]    in_used_percent;
  logic [TSLOT_W-1:0]  in_target_slot;
  logic                out_valid;
  logic                out_ready;
  logic [STATUS_W-1:0] out_status;
  logic [OSLOT_W-1:0]  out_slot_index;
  logic [OLVL_W-1:0]   out_queue_level;
  logic [CHARGE_W-1:0] out_charged_ns;
  int                  fail_count;
  int                  pending_count;
  bit                  no_gaps;

  mlfq_process_scheduler i_dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_real_time_class(in_real_time_class), .in_used_percent(in_used_percent),
    .in_target_slot(in_target_slot),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_slot_index(out_slot_index), .out_queue_level(out_queue_level),
    .out_charged_ns(out_charged_ns)
  );

  mlfq_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_real_time_class(in_real_time_class), .in_used_percent(in_used_percent),
    .in_target_slot(in_target_slot),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_slot_index(out_slot_index), .out_queue_level(out_queue_level),
    .out_charged_ns(out_charged_ns),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [PCT_W-1:0] rand_pct();
    if ($urandom_range(0, 6) == 0) return PCT_W'($urandom_range(0, 127));
    return PCT_W'($urandom_range(0, PCT_FULL));
  endfunction

  task automatic send_word(logic [ACT_W-1:0] act, logic rt, logic [PCT_W-1:0] pct,
                           logic [TSLOT_W-1:0] target);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_action          <= act;
    in_real_time_class <= rt;
    in_used_percent    <= pct;
    in_target_slot     <= target;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_action(logic [ACT_W-1:0] act);
    send_word(act, 1'($urandom_range(0, 1)), rand_pct(), TSLOT_W'($urandom_range(0, 15)));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [PDATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * int'(idx));
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(int words);
    int sent;
    int seq;
    int pick;
    int c;
    sent = 0;
    seq  = 0;
    while (sent < words) begin
      if (seq % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      seq++;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        // dispatch followed by one completion of the running slot
        send_action(ACT_DISPATCH);
        c = $urandom_range(0, 99);
        if (c < 35) send_action(ACT_EXPIRED);
        else if (c < 70) send_action(ACT_EXHAUSTED);
        else send_action(ACT_SLICED);
        sent += 2;
      end else if (pick < 70) begin
        send_action(ACT_CREATE);
        sent++;
      end else if (pick < 85) begin
        send_action(ACT_UNBLOCK);
        sent++;
      end else begin
        send_action(ACT_W'($urandom_range(0, 7)));
        sent++;
      end
    end
    no_gaps = 1'b0;
    drain();
  endtask

  initial begin
    int n;
    int g;
    out_ready <= 1'b0;
    repeat (3) @(posedge clk);
    forever begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 8);
      out_ready <= 1'b1;
      repeat (n) @(posedge clk);
      g = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
      out_ready <= 1'b0;
      repeat (g) @(posedge clk);
    end
  end

  initial begin
    rst_n              <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    in_valid           <= 1'b0;
    in_action          <= ACT_CREATE;
    in_real_time_class <= 1'b0;
    in_used_percent    <= '0;
    in_target_slot     <= '0;
    no_gaps            = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, nothing running, spare codes
    send_word(ACT_DISPATCH, 1'b0, 7'd0, 4'd0);
    send_word(ACT_EXPIRED, 1'b1, 7'd50, 4'd0);
    send_word(ACT_SLICED, 1'b0, 7'd127, 4'd15);
    send_word(ACT_UNBLOCK, 1'b0, 7'd0, 4'd0);
    send_word(ACT_SPARE_LO, 1'b1, 7'd127, 4'd15);
    send_word(ACT_SPARE_HI, 1'b0, 7'd0, 4'd0);
    // one real-time slot at level 0 and one user slot from level 1 down to the bottom level
    send_word(ACT_CREATE, 1'b1, 7'd0, 4'd0);
    send_word(ACT_CREATE, 1'b0, 7'd127, 4'd15);
    send_word(ACT_DISPATCH, 1'b0, 7'd0, 4'd0);
    send_word(ACT_DISPATCH, 1'b0, 7'd0, 4'd0);
    send_word(ACT_EXHAUSTED, 1'b0, 7'd0, 4'd0);
    send_word(ACT_DISPATCH, 1'b0, 7'd0, 4'd0);
    send_word(ACT_SLICED, 1'b0, 7'd127, 4'd0);
    send_word(ACT_UNBLOCK, 1'b1, 7'd0, 4'd0);
    send_word(ACT_UNBLOCK, 1'b0, 7'd0, 4'd0);
    send_word(ACT_DISPATCH, 1'b0, 7'd0, 4'd0);
    send_word(ACT_EXPIRED, 1'b0, 7'd0, 4'd0);
    send_word(ACT_DISPATCH, 1'b0, 7'd0, 4'd0);
    send_word(ACT_EXHAUSTED, 1'b0, 7'd100, 4'd0);
    send_word(ACT_DISPATCH, 1'b0, 7'd0, 4'd0);
    send_word(ACT_EXHAUSTED, 1'b0, 7'd0, 4'd0);
    send_word(ACT_DISPATCH, 1'b0, 7'd0, 4'd0);
    send_word(ACT_EXHAUSTED, 1'b0, 7'd0, 4'd0);
    send_word(ACT_DISPATCH, 1'b0, 7'd0, 4'd0);
    send_word(ACT_EXPIRED, 1'b0, 7'd100, 4'd15);
    drain();

    write_reg(REG_SLOTS, PDATA_W'(31));
    write_reg(REG_BASE, PDATA_W'(BASE_FIELD_MAX));
    run_phase(200);
    write_reg(REG_SLOTS, PDATA_W'(1));
    write_reg(REG_BASE, PDATA_W'(1));
    run_phase(200);
    write_reg(REG_SLOTS, PDATA_W'(0));
    write_reg(REG_BASE, PDATA_W'(BASE_HIGH));
    run_phase(200);
    write_reg(REG_SLOTS, PDATA_W'($urandom_range(2, 15)));
    write_reg(REG_BASE, PDATA_W'($urandom_range(1, 100000000)));
    run_phase(200);
    write_reg(REG_SLOTS, PDATA_W'(SLOTS_RST));
    write_reg(REG_BASE, PDATA_W'(BASE_RST));
    run_phase(200);
    write_reg(REG_SLOTS, PDATA_W'($urandom_range(17, 31)));
    write_reg(REG_BASE, PDATA_W'($urandom_range(1, 1000)));
    run_phase(200);

    repeat (30) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
